// ===== hw/rtl/ppct_pkg.sv =====
// Shared types and constants for the polygon point crossing test.
// Used by ppct_edge and polygon_point_crossing_test; no dependencies.
package ppct_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 16;
	localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
	localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
	localparam int SLOT_BITS    = 6;
	localparam int VC_BITS      = 7;
	localparam int RES_BITS     = 7;
	localparam int D_BITS       = COORD_BITS + 1;
	localparam int P_BITS       = 2 * D_BITS;
	localparam int S_DATA_BITS  = ((SLOT_BITS + 2 * COORD_BITS + 7) / 8) * 8;
	localparam int M_DATA_BITS  = ((1 + 2 * RES_BITS + 7) / 8) * 8;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] x;
	} corner_t;

	typedef struct packed {
		logic busy;
		logic valid;
		logic hit;
		logic left;
	} edge_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} st_t;

	function automatic logic [CNT_BITS-1:0] clamp_count(input logic [VC_BITS-1:0] v);
		if (int'(v) > MAX_VERTICES)
			return CNT_BITS'(MAX_VERTICES);
		return CNT_BITS'(v);
	endfunction

endpackage

// ===== hw/rtl/ppct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/ppct_edge.sv =====
// Edge classifier: forms the edge from the previous and current corner,
// checks the half-open y span and compares the two cross products.
// Depends on ppct_pkg.
module ppct_edge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  logic                first_s1,
	input  ppct_pkg::corner_t   cur_s1,
	input  ppct_pkg::corner_t   point,
	output ppct_pkg::edge_res_t res
);
	import ppct_pkg::*;

	corner_t prev_q;
	corner_t lo, hi;
	logic    span;

	logic                     v_s2, span_s2;
	logic signed [D_BITS-1:0] dhx_s2, dpy_s2, dpx_s2, dhy_s2;
	logic                     v_s3, span_s3;
	logic signed [P_BITS-1:0] p1_s3, p2_s3;

	always_comb begin
		if (prev_q.y <= cur_s1.y) begin
			lo = prev_q;
			hi = cur_s1;
		end else begin
			lo = cur_s1;
			hi = prev_q;
		end
		span = (lo.y <= point.y) && (point.y < hi.y);
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			prev_q <= cur_s1;
		dhx_s2  <= D_BITS'(hi.x) - D_BITS'(lo.x);
		dpy_s2  <= D_BITS'(point.y) - D_BITS'(lo.y);
		dpx_s2  <= D_BITS'(point.x) - D_BITS'(lo.x);
		dhy_s2  <= D_BITS'(hi.y) - D_BITS'(lo.y);
		span_s2 <= span;
		p1_s3   <= dhx_s2 * dpy_s2;
		p2_s3   <= dpx_s2 * dhy_s2;
		span_s3 <= span_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= valid_s1 && !first_s1;
			v_s3 <= v_s2;
		end
	end

	assign res.busy  = v_s2 || v_s3;
	assign res.valid = v_s3;
	assign res.hit   = span_s3;
	assign res.left  = p1_s3 < p2_s3;

endmodule

// ===== hw/rtl/polygon_point_crossing_test.sv =====
// Top level of the polygon point crossing test: vertex RAM, edge walk
// sequencer, crossing counters and result register.
// Depends on ppct_pkg, ppct_ram and ppct_edge.
//
// Load items (tuser 0) write one corner into the vertex RAM. A query item
// (tuser 1) starts a walk, where n is vertex_count limited to the store
// depth: the walk reads one corner per cycle through the single read
// port of the vertex RAM, n + 1 reads in all, followed by a drain state in
// which the three-stage edge pipeline empties and is seen empty, and a
// finish state that presents the result. The input reopens as the result
// appears; a result still held on the output delays the finish state. Only
// one item is worked on at a time; a load may be taken while a result
// still waits on the output. Every slot that a query touches must have
// been loaded before; unwritten slots read as garbage. The user must write
// vertex_count through the cfg channel only while the block is idle; the
// block itself does not enforce this.
module polygon_point_crossing_test (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ppct_pkg::VC_BITS-1:0]     cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic                             s_tuser,  // opcode
	input  logic [ppct_pkg::S_DATA_BITS-1:0] s_tdata,  // slot, coord_x, coord_y, zero pad
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ppct_pkg::M_DATA_BITS-1:0] m_tdata   // inside_res, left_crossings,
	                                                   // right_crossings, zero pad
);
	import ppct_pkg::*;

	st_t st_q, st_d;

	logic [VC_BITS-1:0]   vc_q;
	logic [CNT_BITS-1:0]  n_q;
	logic [CNT_BITS-1:0]  rd_cnt_q;
	corner_t              point_q;
	logic [RES_BITS-1:0]  left_q, right_q;
	logic                 valid_s1, first_s1;
	logic                 m_tvalid_q;
	logic [M_DATA_BITS-1:0] m_tdata_q;

	logic [SLOT_BITS-1:0] in_slot;
	corner_t              in_corner;
	logic                 in_acc, load_we, query_go;
	logic                 rd_en, walk_last, out_load;
	logic [ADDR_BITS-1:0] rd_addr;
	corner_t              rd_corner;
	edge_res_t            edge_res;

	assign cfg_ready = 1'b1;
	assign in_slot     = s_tdata[SLOT_BITS-1:0];
	assign in_corner.x = $signed(s_tdata[SLOT_BITS+COORD_BITS-1:SLOT_BITS]);
	assign in_corner.y = $signed(s_tdata[SLOT_BITS+2*COORD_BITS-1:SLOT_BITS+COORD_BITS]);

	assign in_acc    = s_tvalid && s_tready;
	assign load_we   = in_acc && (s_tuser == OP_LOAD) && (int'(in_slot) < MAX_VERTICES);
	assign query_go  = in_acc && (s_tuser == OP_QUERY);
	assign walk_last = (rd_cnt_q == n_q);
	assign rd_addr   = walk_last ? '0 : rd_cnt_q[ADDR_BITS-1:0];

	ppct_ram #(
		.WIDTH($bits(corner_t)),
		.DEPTH(MAX_VERTICES)
	) u_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(ADDR_BITS'(in_slot)),
		.wdata(in_corner),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_corner)
	);

	ppct_edge u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s1(valid_s1),
		.first_s1(first_s1),
		.cur_s1  (rd_corner),
		.point   (point_q),
		.res     (edge_res)
	);

	always_comb begin
		st_d     = st_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		case (st_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (s_tuser == OP_QUERY))
					st_d = ST_WALK;
			end
			ST_WALK: begin
				rd_en = 1'b1;
				if (walk_last)
					st_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!valid_s1 && !edge_res.busy)
					st_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			vc_q       <= '0;
			rd_cnt_q   <= '0;
			valid_s1   <= 1'b0;
			left_q     <= '0;
			right_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			valid_s1 <= rd_en;
			if (cfg_valid && cfg_ready)
				vc_q <= cfg_data;
			if (query_go) begin
				rd_cnt_q <= '0;
				left_q   <= '0;
				right_q  <= '0;
			end else begin
				if (rd_en)
					rd_cnt_q <= rd_cnt_q + 1'b1;
				if (edge_res.valid && edge_res.hit) begin
					if (edge_res.left)
						left_q <= left_q + 1'b1;
					else
						right_q <= right_q + 1'b1;
				end
			end
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (rd_cnt_q == '0);
		if (query_go) begin
			point_q <= in_corner;
			n_q     <= clamp_count(vc_q);
		end
		if (out_load)
			m_tdata_q <= M_DATA_BITS'({right_q, left_q, left_q[0] & right_q[0]});
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// no edge result may land while the block is idle
	a_edge_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !edge_res.valid)
		else $error("edge result while idle");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WALK) |-> (rd_cnt_q <= n_q))
		else $error("walk counter past vertex count");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(st_q) == ST_FINISH))
		else $error("result raised outside finish");

endmodule

// ===== test/polygon_point_crossing_test_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for polygon_point_crossing_test: loads polygons, queries points
// and checks every crossing count against its own predictor. Depends on ppct_pkg.
module polygon_point_crossing_test_tb;
	import ppct_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES = 500;

	typedef struct packed {
		logic                         opcode;
		logic [SLOT_BITS-1:0]         slot;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} poly_item_t;

	typedef struct packed {
		logic                in_poly;
		logic [RES_BITS-1:0] left;
		logic [RES_BITS-1:0] right;
	} crossing_t;

	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_RARE, RX_PATTERN} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [VC_BITS-1:0]     cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic                   s_tuser = 1'b0;
	logic [S_DATA_BITS-1:0] s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_DATA_BITS-1:0] m_tdata;

	poly_item_t item_q[$];
	crossing_t  crossing_q[$];

	logic signed [COORD_BITS-1:0] poly_x[MAX_VERTICES];
	logic signed [COORD_BITS-1:0] poly_y[MAX_VERTICES];
	logic [VC_BITS-1:0]           vert_count = '0;

	int gen_x[MAX_VERTICES];
	int gen_y[MAX_VERTICES];

	int       cycle_cnt = 0;
	int       pushed_cnt = 0;
	int       accepted_cnt = 0;
	int       fail_cnt = 0;
	int       query_cnt = 0;
	int       load_cnt = 0;
	int       phase_cnt = 0;
	logic     tx_gaps = 1'b0;
	rx_mode_t rx_mode = RX_ALWAYS;
	logic     hold_start = 1'b0;

	polygon_point_crossing_test u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	function automatic crossing_t count_crossings(input logic signed [COORD_BITS-1:0] px,
			input logic signed [COORD_BITS-1:0] py);
		int n, j, lc, rc;
		longint ax, ay, bx, by, lx, ly, hx, hy, qx, qy;
		crossing_t r;
		n = (vert_count > MAX_VERTICES) ? MAX_VERTICES : int'(vert_count);
		lc = 0;
		rc = 0;
		qx = px;
		qy = py;
		for (int i = 0; i < n; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			ax = poly_x[i];
			ay = poly_y[i];
			bx = poly_x[j];
			by = poly_y[j];
			if (ay <= by) begin
				lx = ax; ly = ay; hx = bx; hy = by;
			end else begin
				lx = bx; ly = by; hx = ax; hy = ay;
			end
			if (ly <= qy && qy < hy) begin
				if ((hx - lx) * (qy - ly) < (qx - lx) * (hy - ly))
					lc++;
				else
					rc++;
			end
		end
		r.in_poly = lc[0] & rc[0];
		r.left = RES_BITS'(lc);
		r.right = RES_BITS'(rc);
		return r;
	endfunction

	task automatic note_failure(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%0d: %s", cycle_cnt, msg);
	endtask

	// driver: bursts of items, with random gaps between them when tx_gaps is set
	always @(posedge clk or negedge arst_n) begin : drv
		poly_item_t it;
		int         burst_left;
		int         gap_left;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tuser <= 1'b0;
			s_tdata <= '0;
			burst_left = 0;
			gap_left = 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (item_q.size() != 0) begin
				it = item_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= it.opcode;
				s_tdata <= S_DATA_BITS'({it.y, it.x, it.slot});
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					gap_left = tx_gaps ? $urandom_range(0, 6) : 0;
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// predictor: follow accepted items, store corners, queue expected counts
	always @(posedge clk) begin : predict
		logic [SLOT_BITS-1:0]         slot;
		logic signed [COORD_BITS-1:0] x, y;
		if (arst_n && s_tvalid && s_tready) begin
			slot = s_tdata[SLOT_BITS-1:0];
			x = s_tdata[SLOT_BITS +: COORD_BITS];
			y = s_tdata[SLOT_BITS + COORD_BITS +: COORD_BITS];
			if (s_tuser == OP_LOAD) begin
				poly_x[slot] = x;
				poly_y[slot] = y;
				load_cnt++;
			end else begin
				crossing_q = {crossing_q, count_crossings(x, y)};
			end
			accepted_cnt++;
		end
	end

	// receiver: stall pattern per phase, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin : rcv
		int hold_left;
		int pat;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
			pat = 0;
		end else begin
			pat++;
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_start) begin
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS:  m_tready <= 1'b1;
					RX_RANDOM:  m_tready <= 1'($urandom_range(0, 1));
					RX_RARE:    m_tready <= ($urandom_range(0, 9) != 0);
					RX_PATTERN: m_tready <= (pat % 7) > 2;
					default:    m_tready <= 1'b1;
				endcase
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin : mon
		crossing_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.in_poly = m_tdata[0];
			got.left = m_tdata[1 +: RES_BITS];
			got.right = m_tdata[1 + RES_BITS +: RES_BITS];
			if (crossing_q.size() == 0) begin
				note_failure($sformatf("result with nothing expected: inside %0d left %0d right %0d",
					got.in_poly, got.left, got.right));
			end else begin
				want = crossing_q.pop_front();
				query_cnt++;
				if (got != want)
					note_failure($sformatf(
						"mismatch: expected inside %0d left %0d right %0d, got %0d %0d %0d",
						want.in_poly, want.left, want.right, got.in_poly, got.left, got.right));
			end
		end
	end

	task automatic push_item(input logic op, input int slot, input int x, input int y);
		poly_item_t it;
		it.opcode = op;
		it.slot = SLOT_BITS'(slot);
		it.x = COORD_BITS'(x);
		it.y = COORD_BITS'(y);
		item_q = {item_q, it};
		pushed_cnt++;
		if (op == OP_LOAD) begin
			gen_x[slot] = x;
			gen_y[slot] = y;
		end
	endtask

	task automatic wait_idle();
		while (accepted_cnt != pushed_cnt || crossing_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(input int v);
		cfg_data <= VC_BITS'(v);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		vert_count = VC_BITS'(v);
		phase_cnt++;
	endtask

	function automatic int rand_full();
		logic signed [COORD_BITS-1:0] v;
		v = COORD_BITS'($urandom);
		return v;
	endfunction

	function automatic int rand_coord(input int c, input int s);
		int v;
		v = c - s + int'($urandom_range(0, 2 * s));
		if (v < -32768)
			v = -32768;
		if (v > 32767)
			v = 32767;
		return v;
	endfunction

	initial begin : stim
		int vc, n, nq, cx, cy, span, k, x, y, start_cnt;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no corners: no edges at all
		write_vertex_count(0);
		push_item(OP_QUERY, 0, 0, 0);
		push_item(OP_QUERY, 63, -32768, 32767);
		wait_idle();

		// one corner: a degenerate edge
		write_vertex_count(1);
		push_item(OP_LOAD, 0, 5, 5);
		push_item(OP_QUERY, 0, 5, 5);
		wait_idle();

		// square on the extremes of the coordinate range
		write_vertex_count(4);
		push_item(OP_LOAD, 0, -32768, -32768);
		push_item(OP_LOAD, 1, 32767, -32768);
		push_item(OP_LOAD, 2, 32767, 32767);
		push_item(OP_LOAD, 3, -32768, 32767);
		push_item(OP_QUERY, 0, 0, 0);
		push_item(OP_QUERY, 0, -32768, -32768);
		push_item(OP_QUERY, 0, 32767, 0);
		push_item(OP_QUERY, 0, 0, 32767);
		push_item(OP_QUERY, 0, 32767, 32766);
		wait_idle();

		// triangle with a horizontal edge, points on corners and edges, inside and outside
		write_vertex_count(3);
		push_item(OP_LOAD, 0, 0, 0);
		push_item(OP_LOAD, 1, 10, 0);
		push_item(OP_LOAD, 2, 0, 10);
		push_item(OP_QUERY, 0, 0, 0);
		push_item(OP_QUERY, 0, 5, 0);
		push_item(OP_QUERY, 0, 1, 1);
		push_item(OP_QUERY, 0, 5, 5);
		push_item(OP_QUERY, 0, -1, 5);
		wait_idle();

		start_cnt = pushed_cnt;
		for (int p = 0; pushed_cnt - start_cnt < RANDOM_ITEMS; p++) begin
			case (p)
				0: vc = 127;
				1: vc = 64;
				2: vc = 0;
				3: vc = 1;
				4: vc = 2;
				default: begin
					k = $urandom_range(0, 19);
					if (k < 12)
						vc = $urandom_range(3, 10);
					else if (k < 15)
						vc = $urandom_range(11, 40);
					else if (k < 17)
						vc = $urandom_range(41, 64);
					else if (k < 18)
						vc = $urandom_range(65, 126);
					else
						vc = $urandom_range(3, 6);
				end
			endcase
			rx_mode = rx_mode_t'(p % 4);
			tx_gaps = (p % 3) != 0;
			if (p == 0) begin
				rx_mode = RX_ALWAYS;
				tx_gaps = 1'b0;
			end
			write_vertex_count(vc);
			n = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;

			if ($urandom_range(0, 4) == 0) begin
				cx = 0;
				cy = 0;
				span = 32767;
			end else begin
				cx = rand_full();
				cy = rand_full();
				span = 1 << $urandom_range(2, 9);
			end

			for (int i = 0; i < n; i++) begin
				x = rand_coord(cx, span);
				if (i > 0 && $urandom_range(0, 3) == 0)
					y = gen_y[i-1];
				else
					y = rand_coord(cy, span);
				push_item(OP_LOAD, i, x, y);
			end

			nq = (n <= 12) ? $urandom_range(25, 40) : $urandom_range(6, 12);
			for (int i = 0; i < nq; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					push_item(OP_LOAD, $urandom_range(0, MAX_VERTICES - 1),
						rand_coord(cx, span), rand_coord(cy, span));
				end else begin
					k = (n > 0) ? $urandom_range(0, n - 1) : 0;
					case ($urandom_range(0, 9))
						5, 6: begin
							x = gen_x[k];
							y = gen_y[k];
						end
						7: begin
							x = rand_coord(cx, span);
							y = gen_y[k];
						end
						8: begin
							x = rand_full();
							y = rand_full();
						end
						9: begin
							x = $urandom_range(0, 1) ? -32768 : 32767;
							y = $urandom_range(0, 1) ? -32768 : 32767;
						end
						default: begin
							x = rand_coord(cx, span);
							y = rand_coord(cy, span);
						end
					endcase
					push_item(OP_QUERY, $urandom_range(0, MAX_VERTICES - 1), x, y);
				end
			end

			// hold the output long enough for the block to back up its input
			if (p == 5) begin
				hold_start <= 1'b1;
				@(posedge clk);
				hold_start <= 1'b0;
			end
			wait_idle();
		end

		$display("Covered %0d vertex count settings (0 through 127), %0d corner loads,",
			phase_cnt, load_cnt);
		$display("%0d point queries checked, %0d failures", query_cnt, fail_cnt);
		if (fail_cnt == 0 && crossing_q.size() == 0)
			$display("polygon_point_crossing_test test passed");
		else
			$display("polygon_point_crossing_test test failed");
		$finish;
	end

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT)
			@(posedge clk);
		$display("polygon_point_crossing_test test failed");
		$finish;
	end

endmodule
